// File: rtl/core/sitdt_pkg.sv
package sitdt_pkg;

  localparam int MAG_W = 32;
  localparam int WIDE_W = MAG_W + 2;
  localparam int IDX_W = 4;
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam int SITDT_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [IDX_W-1:0]  top;
  } sitdt_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } sitdt_state_t;

  function automatic logic [WIDE_W-1:0] pow10(input logic [IDX_W-1:0] k);
    logic [WIDE_W-1:0] p;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

  function automatic logic [WIDE_W-1:0] scaled_pow10(input logic [IDX_W-1:0] k,
                                                     input logic [IDX_W-1:0] j);
    logic [WIDE_W-1:0] p;
    p = pow10(k);
    return p * {{(WIDE_W-IDX_W){1'b0}}, j};
  endfunction

endpackage

// File: rtl/core/sitdt_front.sv
module sitdt_front
  import sitdt_pkg::*;
(
  input  logic [MAG_W-1:0] in_value,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             q_full,
  output logic             push,
  output sitdt_item_t      push_item
);

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [IDX_W-1:0] top;

  always_comb begin
    neg = in_value[MAG_W-1];
    mag = neg ? (~in_value + {{(MAG_W-1){1'b0}}, 1'b1}) : in_value;
    top = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, mag} >= pow10(IDX_W'(k))) begin
        top = IDX_W'(k);
      end
    end
  end

  assign in_ready = !q_full;
  assign push = in_valid && !q_full;
  assign push_item = '{neg: neg, mag: mag, top: top};

endmodule

// File: rtl/core/sitdt_queue.sv
module sitdt_queue
  import sitdt_pkg::*;
#(
  parameter int DEPTH = SITDT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sitdt_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output sitdt_item_t q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  sitdt_item_t      mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = count_r == CNT_W'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/sitdt_back.sv
module sitdt_back
  import sitdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sitdt_item_t       q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last_char
);

  sitdt_state_t      state_r, state_nxt;
  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              adv;
  logic [WIDE_W-1:0] thr [0:9];
  logic [IDX_W-1:0]  dig;
  logic [MAG_W-1:0]  rem_after;

  always_comb begin
    thr[0] = '0;
    for (int j = 1; j <= 9; j++) begin
      thr[j] = scaled_pow10(idx_r, IDX_W'(j));
    end
    dig = '0;
    for (int j = 1; j <= 9; j++) begin
      if ({2'b00, rem_r} >= thr[j]) begin
        dig = IDX_W'(j);
      end
    end
    rem_after = MAG_W'({2'b00, rem_r} - thr[dig]);
  end

  assign adv = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    pop = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          rem_nxt = q_item.mag;
          idx_nxt = q_item.top;
          state_nxt = q_item.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt = CHAR_MINUS;
          out_last_nxt = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt = CHAR_ZERO + {{(CHAR_W-IDX_W){1'b0}}, dig};
          out_last_nxt = idx_r == '0;
          rem_nxt = rem_after;
          if (idx_r == '0) begin
            if (q_valid) begin
              pop = 1'b1;
              rem_nxt = q_item.mag;
              idx_nxt = q_item.top;
              state_nxt = q_item.neg ? ST_SIGN : ST_DIGIT;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// File: rtl/core/signed_int_to_decimal_text.sv
// Converts each signed 32-bit in_value into its decimal ASCII text, one character per
// out beat, most significant first, with a leading '-' for negative numbers and
// out_last_char set on the final digit. A number yields 1 to 11 beats and, with the
// result side ready, the digit unit emits one character per cycle, moving from a
// number's last digit straight to the next queued number; a number arriving while
// that unit is idle is first read from the queue in ST_IDLE. Input is taken whenever
// the QUEUE_DEPTH-entry queue between the classifier and the digit unit has room, so
// QUEUE_DEPTH numbers can wait behind the one being emitted.
module signed_int_to_decimal_text
  import sitdt_pkg::*;
#(
  parameter int QUEUE_DEPTH = SITDT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last_char
);

  logic        q_full;
  logic        push;
  sitdt_item_t push_item;
  logic        pop;
  logic        q_valid;
  sitdt_item_t q_item;

  sitdt_front u_front (
    .in_value  (MAG_W'(unsigned'(in_value))),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  sitdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  sitdt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS ||
                   (out_character >= CHAR_ZERO && out_character <= CHAR_ZERO + 6'd9)))
    else $error("illegal output character");

  a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_character == CHAR_MINUS)
      |=> !(out_valid && out_character == CHAR_MINUS))
    else $error("minus sign not followed by a digit");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import sitdt_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  localparam int RESET_CYCLES = 6;
  localparam int MAX_WAIT = 12;
  localparam int RANDOM_ITEMS = 107;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 300;
  localparam int LONG_HOLD_AT = 200;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic signed [31:0] in_value;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] out_character;
  logic              out_last_char;

  logic signed [31:0] pend_values[$];
  text_beat_t         text_exp[$];
  int                 fails = 0;
  int                 tx_gap = 0;
  int                 rx_hold = 0;
  int                 rx_beats = 0;
  int                 idle_cycles = 0;
  bit                 tx_steady = 0;
  bit                 rx_steady = 0;
  bit                 long_hold_done = 0;

  signed_int_to_decimal_text dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void predict_text(input logic [31:0] v);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs[11];
    int          n;
    text_beat_t  b;
    neg = v[31];
    mag = neg ? (~v + 32'd1) : v;
    n = 0;
    do begin
      digs[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end while (mag != 32'd0);
    if (neg) begin
      b.ch = CHAR_MINUS;
      b.last = 1'b0;
      text_exp.push_back(b);
    end
    for (int i = n - 1; i >= 0; i--) begin
      b.ch = CHAR_ZERO + {2'b00, digs[i]};
      b.last = (i == 0);
      text_exp.push_back(b);
    end
  endfunction

  function automatic logic [31:0] random_value();
    int          k;
    longint      lo;
    longint      hi;
    logic [31:0] v;
    if ($urandom_range(0, 4) == 0) return $urandom;
    k = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < k; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (k == 1) lo = 0;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    v = 32'(lo) + $urandom_range(0, 32'(hi - lo));
    if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
    if (v == 32'd0 && $urandom_range(0, 1) == 1) v = 32'h8000_0000;
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_value);
      end
      if (in_valid && !in_ready) begin
        // hold beat until accepted
      end else if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pend_values.size() != 0) begin
        in_valid <= 1'b1;
        in_value <= pend_values.pop_front();
        if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
        tx_gap <= tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    text_beat_t e;
    int         w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        rx_beats <= rx_beats + 1;
        if (text_exp.size() == 0) begin
          $display("%0t: unexpected beat char=%0d last=%0b", $time, out_character,
                   out_last_char);
          fails++;
        end else begin
          e = text_exp.pop_front();
          if (out_character !== e.ch) begin
            $display("%0t: character mismatch expected=%0d actual=%0d", $time, e.ch,
                     out_character);
            fails++;
          end
          if (out_last_char !== e.last) begin
            $display("%0t: last_char mismatch expected=%0b actual=%0b", $time, e.last,
                     out_last_char);
            fails++;
          end
        end
        if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        if (!long_hold_done && rx_beats >= LONG_HOLD_AT) begin
          long_hold_done <= 1'b1;
          w = LONG_HOLD;
        end else begin
          w = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end
        rx_hold <= w;
        out_ready <= (w == 0);
      end else if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= (rx_hold == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    pend_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                    32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                    32'd1000000000, 32'd999999999, -32'sd999999999, 32'd123456789,
                    -32'sd5, 32'd1999999999, -32'sd1000000000, 32'd2000000000,
                    -32'sd9, 32'd5, 32'hAAAA_AAAA, 32'h5555_5555};
    for (int i = 0; i < RANDOM_ITEMS; i++) pend_values.push_back(random_value());
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_values.size() != 0 || in_valid) @(posedge clk);
    while (text_exp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (text_exp.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, text_exp.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
